### rtl/tdffp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdffp_pkg: shared types for the two-dimensional first-fit packer
// Command and result codes, controller states and the result record.
// ----------------------------------------------------------------------------
package tdffp_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_PACK  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_e_t;

	typedef enum logic [1:0] {
		KIND_ACK     = 2'd0,
		KIND_ORDER   = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_e_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SUMMARY
	} state_e_t;

	typedef struct packed {
		kind_e_t     kind;
		logic [4:0]  order_index;
		logic [15:0] out_weight;
		logic [15:0] out_volume;
		logic        bin_used;
		logic        store_full;
		logic        last;
	} result_t;

endpackage
`default_nettype wire

### rtl/tdffp_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdffp_req_if: request channel
// Command with a volume and a weight, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tdffp_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] item_volume;
	logic [15:0] item_weight;

	modport source (output valid, command, item_volume, item_weight, input ready);
	modport sink (input valid, command, item_volume, item_weight, output ready);
endinterface
`default_nettype wire

### rtl/tdffp_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdffp_res_if: result channel
// Acknowledges, packed orders and bin summaries, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tdffp_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [4:0]  order_index;
	logic [15:0] out_weight;
	logic [15:0] out_volume;
	logic        bin_used;
	logic        store_full;
	logic        last;

	modport source (output valid, kind, order_index, out_weight, out_volume, bin_used,
		store_full, last, input ready);
	modport sink (input valid, kind, order_index, out_weight, out_volume, bin_used,
		store_full, last, output ready);
endinterface
`default_nettype wire

### rtl/tdffp_order_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdffp_order_mem: order store
// One write port, one read port, registered read data held when not enabled.
// ----------------------------------------------------------------------------
module tdffp_order_mem #(
	parameter int ORDERS = 32,
	parameter int AW     = 5
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [15:0]   wr_volume,
	input  wire logic [15:0]   wr_weight,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [15:0]   rd_volume,
	output logic      [15:0]   rd_weight
);
	logic [31:0] mem [ORDERS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_volume, wr_weight};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			{rd_volume, rd_weight} <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

### rtl/tdffp_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdffp_out_reg: result output register
// Holds one result until the sink takes it; reports when it can take another.
// ----------------------------------------------------------------------------
module tdffp_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire tdffp_pkg::result_t push_data,
	output logic                   out_free,
	tdffp_res_if.source            res
);
	import tdffp_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign out_free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end

	assign res.valid       = valid_q;
	assign res.kind        = data_q.kind;
	assign res.order_index = data_q.order_index;
	assign res.out_weight  = data_q.out_weight;
	assign res.out_volume  = data_q.out_volume;
	assign res.bin_used    = data_q.bin_used;
	assign res.store_full  = data_q.store_full;
	assign res.last        = data_q.last;
endmodule
`default_nettype wire

### rtl/tdffp_scan_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdffp_scan_ctrl: command decode and pack scan
// Pending bits, fill count, remaining bin capacity and the scan sequencer.
// ----------------------------------------------------------------------------
module tdffp_scan_ctrl #(
	parameter int ORDERS = 32,
	parameter int IW     = 5,
	parameter int CW     = 6
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire logic [1:0]     req_command,
	input  wire logic [15:0]    req_volume,
	input  wire logic [15:0]    req_weight,
	input  wire logic           out_free,
	output logic                push,
	output tdffp_pkg::result_t  push_data,
	output logic                mem_wr_en,
	output logic      [IW-1:0]  mem_wr_addr,
	output logic                mem_rd_en,
	output logic      [IW-1:0]  mem_rd_addr,
	input  wire logic [15:0]    mem_rd_volume,
	input  wire logic [15:0]    mem_rd_weight
);
	import tdffp_pkg::*;

	state_e_t      state_q, state_d;
	logic [ORDERS-1:0] pend_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] scan_cnt_q;
	logic [15:0]   rem_vol_q, rem_wgt_q;
	logic          packed_any_q;
	logic [15:0]   cap_vol_q, cap_wgt_q;
	logic          s2_v_q;
	logic [IW-1:0] idx_s2;

	cmd_e_t cmd;
	logic   accept, full, issue_v, fit, adv, take;

	assign cmd       = cmd_e_t'(req_command);
	assign req_ready = (state_q == ST_IDLE) && out_free;
	assign accept    = req_valid && req_ready;
	assign full      = (count_q == CW'(ORDERS));
	assign issue_v   = (scan_cnt_q != CW'(ORDERS));
	// stage 2: read data of entry idx_s2 is on the memory output
	assign fit  = s2_v_q && pend_q[idx_s2] && (mem_rd_volume <= rem_vol_q)
		&& (mem_rd_weight <= rem_wgt_q);
	assign adv  = !fit || out_free;
	assign take = (state_q == ST_SCAN) && fit && out_free;

	assign mem_wr_en   = accept && (cmd == CMD_LOAD) && !full;
	assign mem_wr_addr = count_q[IW-1:0];
	assign mem_rd_addr = scan_cnt_q[IW-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd == CMD_PACK) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!issue_v && (!s2_v_q || adv)) begin
					state_d = ST_SUMMARY;
				end
			end
			ST_SUMMARY: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		push      = 1'b0;
		push_data = '0;
		mem_rd_en = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd != CMD_PACK) begin
					push                 = 1'b1;
					push_data.kind       = KIND_ACK;
					push_data.store_full = (cmd == CMD_LOAD) && full;
					push_data.last       = 1'b1;
				end
			end
			ST_SCAN: begin
				mem_rd_en = adv && issue_v;
				if (take) begin
					push                  = 1'b1;
					push_data.kind        = KIND_ORDER;
					push_data.order_index = 5'(idx_s2);
					push_data.out_weight  = mem_rd_weight;
					push_data.out_volume  = mem_rd_volume;
				end
			end
			ST_SUMMARY: begin
				if (out_free) begin
					push                 = 1'b1;
					push_data.kind       = KIND_SUMMARY;
					push_data.out_weight = cap_wgt_q;
					push_data.out_volume = cap_vol_q;
					push_data.bin_used   = packed_any_q;
					push_data.last       = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pend_q       <= '0;
			count_q      <= '0;
			scan_cnt_q   <= '0;
			rem_vol_q    <= '0;
			rem_wgt_q    <= '0;
			packed_any_q <= 1'b0;
			s2_v_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				unique case (cmd)
					CMD_CLEAR: begin
						pend_q  <= '0;
						count_q <= '0;
					end
					CMD_LOAD: begin
						if (!full) begin
							pend_q[count_q[IW-1:0]] <= 1'b1;
							count_q                 <= count_q + CW'(1);
						end
					end
					CMD_PACK: begin
						rem_vol_q    <= req_volume;
						rem_wgt_q    <= req_weight;
						packed_any_q <= 1'b0;
						scan_cnt_q   <= '0;
						s2_v_q       <= 1'b0;
					end
					default: ;
				endcase
			end
			if (state_q == ST_SCAN && adv) begin
				s2_v_q <= issue_v;
				if (issue_v) begin
					scan_cnt_q <= scan_cnt_q + CW'(1);
				end
			end
			if (take) begin
				rem_vol_q      <= rem_vol_q - mem_rd_volume;
				rem_wgt_q      <= rem_wgt_q - mem_rd_weight;
				pend_q[idx_s2] <= 1'b0;
				packed_any_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_PACK) begin
			cap_vol_q <= req_volume;
			cap_wgt_q <= req_weight;
		end
		if (state_q == ST_SCAN && adv) begin
			idx_s2 <= scan_cnt_q[IW-1:0];
		end
	end
endmodule
`default_nettype wire

### rtl/two_dim_first_fit_packer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_dim_first_fit_packer: greedy first-fit packer over a stored order list
// Loads orders into a store, then packs one bin per pack request in load order.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                        handshake
//  req      in   command, item_volume, item_weight              valid/ready
//  res      out  kind, order_index, out_weight, out_volume,     valid/ready
//                bin_used, store_full, last
//
// clear, load and unused commands: one acknowledge each.
// pack: the scan reads one store entry per cycle through the read port of the
// order memory while no result waits on a busy output register; the summary
// is pushed after the last entry is checked, and the next request can be taken
// once the block is idle again and the output register is free.
// reset: asynchronous, clears pending bits, fill count and bin state; no sweep.
// a stalled result sink freezes the scan; requests are taken only when idle.
// ----------------------------------------------------------------------------
module two_dim_first_fit_packer #(
	parameter int ORDERS = 32
) (
	input wire logic    clk,
	input wire logic    arst_n,
	tdffp_req_if.sink   req,
	tdffp_res_if.source res
);
	import tdffp_pkg::*;

	localparam int IW = (ORDERS > 1) ? $clog2(ORDERS) : 1;
	localparam int CW = $clog2(ORDERS + 1);

	logic          out_free;
	logic          push;
	result_t       push_data;
	logic          mem_wr_en, mem_rd_en;
	logic [IW-1:0] mem_wr_addr, mem_rd_addr;
	logic [15:0]   mem_rd_volume, mem_rd_weight;

	tdffp_scan_ctrl #(
		.ORDERS (ORDERS),
		.IW     (IW),
		.CW     (CW)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req.valid),
		.req_ready     (req.ready),
		.req_command   (req.command),
		.req_volume    (req.item_volume),
		.req_weight    (req.item_weight),
		.out_free      (out_free),
		.push          (push),
		.push_data     (push_data),
		.mem_wr_en     (mem_wr_en),
		.mem_wr_addr   (mem_wr_addr),
		.mem_rd_en     (mem_rd_en),
		.mem_rd_addr   (mem_rd_addr),
		.mem_rd_volume (mem_rd_volume),
		.mem_rd_weight (mem_rd_weight)
	);

	tdffp_order_mem #(
		.ORDERS (ORDERS),
		.AW     (IW)
	) u_mem (
		.clk       (clk),
		.wr_en     (mem_wr_en),
		.wr_addr   (mem_wr_addr),
		.wr_volume (req.item_volume),
		.wr_weight (req.item_weight),
		.rd_en     (mem_rd_en),
		.rd_addr   (mem_rd_addr),
		.rd_volume (mem_rd_volume),
		.rd_weight (mem_rd_weight)
	);

	tdffp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.out_free  (out_free),
		.res       (res)
	);

	// a result is never pushed over one that is still waiting
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed into occupied output register");

	// a packed order never closes a request
	a_order_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.kind == KIND_ORDER) |-> !res.last)
		else $error("packed order flagged as last");

	// memory write and scan read never happen in the same cycle
	a_no_wr_during_scan: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> !mem_rd_en)
		else $error("store written during a scan");

	// after a summary is pushed the block is ready unless the output still holds a waiting result
	a_summary_then_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_data.kind == KIND_SUMMARY) |=> (req.ready || (res.valid && !res.ready)))
		else $error("block not idle after bin summary");
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the two-dimensional first-fit packer
// A short table of directed requests, then random clear/load/pack sequences.
// Each result is checked against its table row or a first-fit predictor. Both
// channels idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
	import tdffp_pkg::*;

	localparam int SLOTS           = 32;
	localparam int DIRECTED_ROWS   = 15;
	localparam int RANDOM_REQUESTS = 125;
	localparam int STALL_LIMIT     = 2000;
	localparam int DRAIN_CYCLES    = 40;
	localparam int LONG_HOLD       = 300;

	localparam result_t ACK_OK = '{KIND_ACK, 5'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1};
	localparam result_t NO_RES = '{KIND_ACK, 5'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0};

	typedef struct {
		cmd_e_t      cmd;
		logic [15:0] vol;
		logic [15:0] wgt;
		bit          typed;
		result_t     res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	tdffp_req_if req_ch ();
	tdffp_res_if res_ch ();

	two_dim_first_fit_packer #(
		.ORDERS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [15:0]      slot_volume [SLOTS];
	logic [15:0]      slot_weight [SLOTS];
	logic [SLOTS-1:0] slot_pending = '0;
	int               slot_count = 0;
	logic [15:0]      room_volume = '0;
	logic [15:0]      room_weight = '0;
	bit               took_any = 1'b0;

	result_t   fit_results[$];
	result_t   expected_results[$];
	stim_row_t directed_rows [DIRECTED_ROWS];

	int errors = 0;
	int requests_sent = 0;
	int orders_packed = 0;
	int bins_used = 0;
	int bins_empty = 0;
	int loads_dropped = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;
	bit hold_results = 1'b0;

	// first-fit over the stored orders in load order
	task automatic first_fit_predict(input cmd_e_t cmd, input logic [15:0] vol,
		input logic [15:0] wgt);
		result_t r;
		fit_results.delete();
		r = '0;
		r.kind = KIND_ACK;
		r.last = 1'b1;
		case (cmd)
			CMD_CLEAR: begin
				slot_pending = '0;
				slot_count = 0;
				fit_results.insert(fit_results.size(), r);
			end
			CMD_LOAD: begin
				if (slot_count >= SLOTS) begin
					r.store_full = 1'b1;
				end else begin
					slot_volume[slot_count] = vol;
					slot_weight[slot_count] = wgt;
					slot_pending[slot_count] = 1'b1;
					slot_count++;
				end
				fit_results.insert(fit_results.size(), r);
			end
			CMD_PACK: begin
				room_volume = vol;
				room_weight = wgt;
				took_any = 1'b0;
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_pending[i] && slot_volume[i] <= room_volume &&
						slot_weight[i] <= room_weight) begin
						room_volume = room_volume - slot_volume[i];
						room_weight = room_weight - slot_weight[i];
						slot_pending[i] = 1'b0;
						took_any = 1'b1;
						r = '0;
						r.kind = KIND_ORDER;
						r.order_index = 5'(i);
						r.out_weight = slot_weight[i];
						r.out_volume = slot_volume[i];
						fit_results.insert(fit_results.size(), r);
					end
				end
				r = '0;
				r.kind = KIND_SUMMARY;
				r.out_weight = wgt;
				r.out_volume = vol;
				r.bin_used = took_any;
				r.last = 1'b1;
				fit_results.insert(fit_results.size(), r);
			end
			default: begin
				fit_results.insert(fit_results.size(), r);
			end
		endcase
	endtask

	task automatic send_request(input cmd_e_t cmd, input logic [15:0] vol,
		input logic [15:0] wgt, input bit typed, input result_t typed_res);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.item_volume <= vol;
		req_ch.item_weight <= wgt;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		first_fit_predict(cmd, vol, wgt);
		if (typed) begin
			expected_results.insert(expected_results.size(), typed_res);
		end else begin
			foreach (fit_results[k])
				expected_results.insert(expected_results.size(), fit_results[k]);
		end
		requests_sent++;
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// stimulus
	initial begin
		int random_start;
		int n_orders;
		int n_bins;
		int mode;
		int top;
		int cap_top;
		int t;
		int seq_vol [SLOTS + 8];
		int seq_wgt [SLOTS + 8];
		bit fill_done;

		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.command <= CMD_CLEAR;
		req_ch.item_volume <= '0;
		req_ch.item_weight <= '0;
		fill_done = 1'b0;

		directed_rows = '{
			// empty store right after reset: summary only
			'{CMD_PACK, 16'hFFFF, 16'hFFFF, 1'b1,
				'{KIND_SUMMARY, 5'd0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1}},
			'{CMD_NONE, 16'hFFFF, 16'hFFFF, 1'b1, ACK_OK},
			'{CMD_LOAD, 16'h0000, 16'h0000, 1'b1, ACK_OK},
			'{CMD_LOAD, 16'hFFFF, 16'hFFFF, 1'b1, ACK_OK},
			'{CMD_LOAD, 16'h0001, 16'hFFFF, 1'b1, ACK_OK},
			'{CMD_LOAD, 16'hFFFF, 16'h0001, 1'b1, ACK_OK},
			'{CMD_LOAD, 16'h1234, 16'h0100, 1'b1, ACK_OK},
			// zero-sized order fits a zero bin
			'{CMD_PACK, 16'h0000, 16'h0000, 1'b0, NO_RES},
			'{CMD_PACK, 16'hFFFF, 16'h0001, 1'b0, NO_RES},
			'{CMD_PACK, 16'hFFFF, 16'hFFFF, 1'b0, NO_RES},
			'{CMD_PACK, 16'h5555, 16'hAAAA, 1'b0, NO_RES},
			'{CMD_CLEAR, 16'h0000, 16'h0000, 1'b1, ACK_OK},
			'{CMD_PACK, 16'hAAAA, 16'h5555, 1'b1,
				'{KIND_SUMMARY, 5'd0, 16'h5555, 16'hAAAA, 1'b0, 1'b0, 1'b1}},
			'{CMD_LOAD, 16'h0800, 16'h0400, 1'b1, ACK_OK},
			'{CMD_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1, ACK_OK}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			send_request(directed_rows[r].cmd, directed_rows[r].vol, directed_rows[r].wgt,
				directed_rows[r].typed, directed_rows[r].res);

		random_start = requests_sent;
		while (requests_sent - random_start < RANDOM_REQUESTS) begin
			quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0) begin
				// noise: any command, any payload
				send_request(cmd_e_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
					1'b0, NO_RES);
			end else begin
				if (!fill_done && requests_sent - random_start > 40) begin
					// overfill the store while the result side holds off
					fill_done = 1'b1;
					hold_results = 1'b1;
					n_orders = SLOTS + 4;
					send_request(CMD_CLEAR, 16'($urandom), 16'($urandom), 1'b0, NO_RES);
				end else begin
					n_orders = $urandom_range(1, 12);
					if ($urandom_range(0, 3) != 0)
						send_request(CMD_CLEAR, 16'($urandom), 16'($urandom), 1'b0, NO_RES);
				end
				mode = $urandom_range(0, 2);
				top = (mode == 0) ? 255 : (mode == 1) ? 4095 : 65535;
				cap_top = (top * 4 > 65535) ? 65535 : top * 4;
				for (int i = 0; i < n_orders; i++) begin
					seq_vol[i] = $urandom_range(0, top);
					seq_wgt[i] = $urandom_range(0, top);
				end
				// sender sorts by descending volume plus weight, skipped now and then
				if ($urandom_range(0, 4) != 0) begin
					for (int i = 0; i < n_orders - 1; i++) begin
						for (int j = 0; j < n_orders - 1 - i; j++) begin
							if (seq_vol[j] + seq_wgt[j] < seq_vol[j+1] + seq_wgt[j+1]) begin
								t = seq_vol[j];
								seq_vol[j] = seq_vol[j+1];
								seq_vol[j+1] = t;
								t = seq_wgt[j];
								seq_wgt[j] = seq_wgt[j+1];
								seq_wgt[j+1] = t;
							end
						end
					end
				end
				for (int i = 0; i < n_orders; i++)
					send_request(CMD_LOAD, 16'(seq_vol[i]), 16'(seq_wgt[i]), 1'b0, NO_RES);
				n_bins = $urandom_range(1, 4);
				repeat (n_bins) begin
					if ($urandom_range(0, 5) == 0)
						send_request(CMD_PACK, 16'hFFFF, 16'hFFFF, 1'b0, NO_RES);
					else
						send_request(CMD_PACK, 16'($urandom_range(0, cap_top)),
							16'($urandom_range(0, cap_top)), 1'b0, NO_RES);
				end
			end
		end
		req_ch.valid <= 1'b0;

		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests sent; %0d orders packed into %0d bins, %0d bins left empty",
			requests_sent, orders_packed, bins_used, bins_empty);
		$display("%0d loads turned away by a full store, %0d mismatches",
			loads_dropped, errors);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// result side: random hold-off per result, one long hold on request
	initial begin
		int gap;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 7);
			if (hold_results) begin
				hold_results = 1'b0;
				gap = LONG_HOLD;
			end
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin : result_monitor
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result kind %0d expected none actual one", $time, res_ch.kind);
				errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("kind", want.kind, res_ch.kind);
				check_field("order_index", want.order_index, res_ch.order_index);
				check_field("out_weight", want.out_weight, res_ch.out_weight);
				check_field("out_volume", want.out_volume, res_ch.out_volume);
				check_field("bin_used", want.bin_used, res_ch.bin_used);
				check_field("store_full", want.store_full, res_ch.store_full);
				check_field("last", want.last, res_ch.last);
			end
			case (kind_e_t'(res_ch.kind))
				KIND_ORDER: orders_packed++;
				KIND_SUMMARY: begin
					if (res_ch.bin_used)
						bins_used++;
					else
						bins_empty++;
				end
				default: begin
					if (res_ch.store_full)
						loads_dropped++;
				end
			endcase
		end
	end

	// watchdog: cycles with no request or result taken
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, idle_cycles);
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
